// ===== hdl/alsu_pkg.sv =====
`timescale 1ns / 1ps

package alsu_pkg;

    localparam int COURANT_W   = 16;
    localparam int K_W         = 31;
    localparam int ROUND_SHIFT = 34;
    localparam int LEFT_SHIFT  = 18;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;

    localparam logic [COURANT_W:0]   ONE_Q16       = 17'h10000;
    localparam logic                 MODE_RESET    = 1'b1;
    localparam logic [COURANT_W-1:0] COURANT_RESET = 16'h8000;
    localparam logic                 REG_MODE      = 1'b0;
    localparam logic                 REG_COURANT   = 1'b1;
    localparam logic [1:0]           FILL_FULL     = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ML0,
        ST_ML1,
        ST_MD0,
        ST_MD1,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        MS_LEFT_LO,
        MS_LEFT_HI,
        MS_D_LO,
        MS_D_HI
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     lim_en;
        logic     d_en;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_en;
        logic     fin_en;
    } dp_cmd_t;

    typedef struct packed {
        logic compute;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/alsu_regs.sv =====
`timescale 1ns / 1ps

module alsu_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [alsu_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [alsu_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [alsu_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic                            mode,
    output logic [alsu_pkg::COURANT_W-1:0]  courant
);
    import alsu_pkg::*;

    logic                 mode_reg;
    logic                 mode_next;
    logic [COURANT_W-1:0] courant_reg;
    logic [COURANT_W-1:0] courant_next;
    logic                 wr_en;
    logic                 reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_comb
    begin
        mode_next    = mode_reg;
        courant_next = courant_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_MODE:    mode_next    = pwdata[0];
                REG_COURANT: courant_next = pwdata[COURANT_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RESET;
            courant_reg <= COURANT_RESET;
        end
        else
        begin
            mode_reg    <= mode_next;
            courant_reg <= courant_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_MODE:    prdata = CFG_DATA_W'(mode_reg);
            REG_COURANT: prdata = CFG_DATA_W'(courant_reg);
            default:     prdata = '0;
        endcase
    end

    assign mode    = mode_reg;
    assign courant = courant_reg;

endmodule

// ===== hdl/alsu_ctrl.sv =====
`timescale 1ns / 1ps

module alsu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  alsu_pkg::dp_status_t status,
    output logic                 in_ready,
    output alsu_pkg::dp_cmd_t    cmd
);
    import alsu_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.compute)
                begin
                    state_next = ST_ML0;
                end
            end
            ST_ML0: state_next = ST_ML1;
            ST_ML1: state_next = ST_MD0;
            ST_MD0: state_next = ST_MD1;
            ST_MD1: state_next = ST_FIN;
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.mul_sel = MS_LEFT_LO;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_ML0:
            begin
                cmd.lim_en  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_LEFT_LO;
            end
            ST_ML1:
            begin
                cmd.d_en    = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_LEFT_HI;
                cmd.acc_en  = 1'b1;
            end
            ST_MD0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_D_LO;
                cmd.acc_en  = 1'b1;
            end
            ST_MD1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_D_HI;
                cmd.acc_en  = 1'b1;
            end
            ST_FIN:
            begin
                cmd.fin_en = status.out_free;
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/alsu_dp.sv =====
`timescale 1ns / 1ps

module alsu_dp #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  alsu_pkg::dp_cmd_t              cmd,
    input  logic signed [SAMPLE_BITS-1:0]  sample,
    input  logic                           row_start,
    input  logic                           mode,
    input  logic [alsu_pkg::COURANT_W-1:0] courant,
    input  logic                           out_ready,
    output alsu_pkg::dp_status_t           status,
    output logic                           out_valid,
    output logic signed [SAMPLE_BITS-1:0]  new_value
);
    import alsu_pkg::*;

    localparam int N      = SAMPLE_BITS;
    localparam int DIFF_W = N + 1;
    localparam int LIM_W  = N + 3;
    localparam int MAG_W  = N + 4;
    localparam int HALF_W = (MAG_W + 1) / 2;
    localparam int PROD_W = HALF_W + K_W;
    localparam int ACC_W  = N + 38;
    localparam int RES_W  = ACC_W - ROUND_SHIFT;

    // limited slope in half-LSB units
    function automatic logic signed [LIM_W-1:0] limit_f(
        input logic signed [DIFF_W-1:0] l,
        input logic signed [DIFF_W-1:0] r
    );
        logic signed [LIM_W-1:0] lx;
        logic signed [LIM_W-1:0] rx;
        logic signed [LIM_W-1:0] sx;
        logic [LIM_W-1:0]        al4;
        logic [LIM_W-1:0]        ar4;
        logic [LIM_W-1:0]        asum;
        logic [LIM_W-1:0]        m;
        logic                    same;
        lx   = LIM_W'(l);
        rx   = LIM_W'(r);
        sx   = lx + rx;
        al4  = (lx[LIM_W-1] ? -lx : lx) << 2;
        ar4  = (rx[LIM_W-1] ? -rx : rx) << 2;
        asum = sx[LIM_W-1] ? -sx : sx;
        same = (lx[LIM_W-1] == rx[LIM_W-1]) && (|lx) && (|rx);
        m    = al4;
        if (asum < m)
        begin
            m = asum;
        end
        if (ar4 < m)
        begin
            m = ar4;
        end
        if (!same)
        begin
            return '0;
        end
        return rx[LIM_W-1] ? -$signed(m) : $signed(m);
    endfunction

    logic signed [N-1:0]      window_reg [3];
    logic [1:0]               fill_reg;
    logic [1:0]               fill_next;
    logic signed [DIFF_W-1:0] left_reg;
    logic signed [DIFF_W-1:0] right_reg;
    logic signed [DIFF_W-1:0] prev_reg;
    logic signed [LIM_W-1:0]  lim_a_reg;
    logic signed [LIM_W-1:0]  lim_b_reg;
    logic signed [MAG_W-1:0]  d_reg;
    logic [K_W-1:0]           k_reg;
    logic [PROD_W-1:0]        prod_reg;
    mul_sel_t                 prod_sel_reg;
    logic                     prod_neg_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [N-1:0]      new_value_reg;

    logic signed [MAG_W-1:0]  left_x;
    logic [MAG_W-1:0]         left_mag;
    logic [MAG_W-1:0]         d_mag;
    logic [HALF_W-1:0]        mul_a;
    logic [K_W-1:0]           mul_b;
    logic                     mul_neg;
    logic [ACC_W-1:0]         shifted;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [ACC_W-1:0]  acc_init;
    logic signed [RES_W-1:0]  res;
    logic signed [N-1:0]      res_sat;
    logic [RES_W-N:0]         res_top;
    logic [COURANT_W:0]       one_minus_c;

    assign status.compute  = !row_start && (fill_reg == FILL_FULL);
    assign status.out_free = !out_valid_reg || out_ready;

    assign one_minus_c = ONE_Q16 - (COURANT_W + 1)'(courant);

    assign left_x   = MAG_W'(left_reg);
    assign left_mag = left_x[MAG_W-1] ? MAG_W'(-left_x) : MAG_W'(left_x);
    assign d_mag    = d_reg[MAG_W-1] ? MAG_W'(-d_reg) : MAG_W'(d_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            MS_LEFT_LO:
            begin
                mul_a   = left_mag[HALF_W-1:0];
                mul_b   = K_W'(courant);
                mul_neg = left_reg[DIFF_W-1];
            end
            MS_LEFT_HI:
            begin
                mul_a   = HALF_W'(left_mag[MAG_W-1:HALF_W]);
                mul_b   = K_W'(courant);
                mul_neg = left_reg[DIFF_W-1];
            end
            MS_D_LO:
            begin
                mul_a   = d_mag[HALF_W-1:0];
                mul_b   = k_reg;
                mul_neg = d_reg[MAG_W-1];
            end
            MS_D_HI:
            begin
                mul_a   = HALF_W'(d_mag[MAG_W-1:HALF_W]);
                mul_b   = k_reg;
                mul_neg = d_reg[MAG_W-1];
            end
            default:
            begin
                mul_a   = '0;
                mul_b   = '0;
                mul_neg = 1'b0;
            end
        endcase
    end

    // both terms are subtracted: a negative operand adds its magnitude
    always_comb
    begin
        case (prod_sel_reg)
            MS_LEFT_LO: shifted = ACC_W'(prod_reg) << LEFT_SHIFT;
            MS_LEFT_HI: shifted = ACC_W'(prod_reg) << (LEFT_SHIFT + HALF_W);
            MS_D_LO:    shifted = ACC_W'(prod_reg);
            MS_D_HI:    shifted = ACC_W'(prod_reg) << HALF_W;
            default:    shifted = '0;
        endcase
    end

    assign acc_sum  = prod_neg_reg ? acc_reg + $signed(shifted) : acc_reg - $signed(shifted);
    assign acc_init = (ACC_W'(window_reg[2]) <<< ROUND_SHIFT)
                    + (ACC_W'(1) <<< (ROUND_SHIFT - 1));

    assign res     = acc_sum[ACC_W-1:ROUND_SHIFT];
    assign res_top = res[RES_W-1:N-1];

    always_comb
    begin
        if ((&res_top) || !(|res_top))
        begin
            res_sat = res[N-1:0];
        end
        else if (res[RES_W-1])
        begin
            res_sat = {1'b1, {(N - 1){1'b0}}};
        end
        else
        begin
            res_sat = {1'b0, {(N - 1){1'b1}}};
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.load)
        begin
            if (row_start)
            begin
                fill_next = 2'd1;
            end
            else if (fill_reg != FILL_FULL)
            begin
                fill_next = fill_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.fin_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= K_W'(courant * one_minus_c);
        if (cmd.load)
        begin
            if (row_start)
            begin
                window_reg[0] <= sample;
            end
            else if (fill_reg != FILL_FULL)
            begin
                window_reg[fill_reg] <= sample;
            end
            else
            begin
                left_reg      <= DIFF_W'(window_reg[2]) - DIFF_W'(window_reg[1]);
                right_reg     <= DIFF_W'(sample) - DIFF_W'(window_reg[2]);
                prev_reg      <= DIFF_W'(window_reg[1]) - DIFF_W'(window_reg[0]);
                acc_reg       <= acc_init;
                window_reg[0] <= window_reg[1];
                window_reg[1] <= window_reg[2];
                window_reg[2] <= sample;
            end
        end
        if (cmd.lim_en)
        begin
            lim_a_reg <= limit_f(left_reg, right_reg);
            lim_b_reg <= limit_f(prev_reg, left_reg);
        end
        if (cmd.d_en)
        begin
            d_reg <= mode ? MAG_W'(lim_a_reg) - MAG_W'(lim_b_reg) : '0;
        end
        if (cmd.mul_en)
        begin
            prod_reg     <= PROD_W'(mul_a) * PROD_W'(mul_b);
            prod_sel_reg <= cmd.mul_sel;
            prod_neg_reg <= mul_neg;
        end
        if (cmd.acc_en)
        begin
            acc_reg <= acc_sum;
        end
        if (cmd.fin_en)
        begin
            new_value_reg <= res_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_value = new_value_reg;

endmodule

// ===== hdl/advection_limited_slope_update_top.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       tdata: sample; tuser: row_start
// m_*       out  m_tvalid / m_tready       tdata: new_value
// apb       in   psel, penable, pready     0x0 mode, 0x4 courant
//
// A sample that only fills the window is taken in idle. One that completes it
// goes through accept, four passes through the shared half-width multiplier
// (two for c*left, two for k*d), and a final add with saturation.
// A result waits in the output register while the next sample is accepted.
// Reset clears the window fill count and the output valid; registers reset to
// mode 1, courant 0x8000. A stalled output holds the block in its final step.

module advection_limited_slope_update_top #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // sample
    input  logic                            s_tuser,  // row_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,  // new_value
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [alsu_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [alsu_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [alsu_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import alsu_pkg::*;

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    dp_cmd_t                       cmd;
    dp_status_t                    status;
    logic                          mode;
    logic [COURANT_W-1:0]          courant;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [SAMPLE_BITS-1:0] new_value;

    assign sample  = $signed(s_tdata[SAMPLE_BITS-1:0]);
    assign m_tdata = TDATA_W'($unsigned(new_value));

    alsu_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mode    (mode),
        .courant (courant)
    );

    alsu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    alsu_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sample    (sample),
        .row_start (s_tuser),
        .mode      (mode),
        .courant   (courant),
        .out_ready (m_tready),
        .status    (status),
        .out_valid (m_tvalid),
        .new_value (new_value)
    );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import alsu_pkg::*;

    localparam int SAMPLE_BITS    = 24;
    localparam int DATA_W         = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam logic [CFG_ADDR_W-1:0] ADDR_MODE    = {REG_MODE, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_COURANT = {REG_COURANT, 2'b00};
    localparam int SECTION_ITEMS  = 225;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int
    {
        PROF_NOISE,
        PROF_WALK,
        PROF_EXTREME,
        PROF_RAMP
    } profile_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata  = '0;   // [23:0] sample
    logic                  s_tuser  = 1'b0; // [0] row_start
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_W-1:0]     m_tdata;         // [23:0] new_value
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // model state
    longint                 centre_win [3];
    int                     win_fill;
    logic                   cfg_mode    = MODE_RESET;
    logic [COURANT_W-1:0]   cfg_courant = COURANT_RESET;
    logic [SAMPLE_BITS-1:0] expected_values [$];
    logic [SAMPLE_BITS-1:0] expected_value;

    int   errors          = 0;
    int   samples_taken   = 0;
    int   updates_checked = 0;
    int   idle_cycles     = 0;
    logic watchdog_fired  = 1'b0;
    int   tx_idle_pct     = 0;
    int   rx_stall_pct    = 0;
    int   hold_token      = 0;
    int   hold_done       = 0;
    int   hold_left       = 0;

    advection_limited_slope_update_top #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    function automatic longint abs_val(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp_sample(input longint v);
        if (v > SAMPLE_MAX)
            return SAMPLE_MAX;
        if (v < SAMPLE_MIN)
            return SAMPLE_MIN;
        return v;
    endfunction

    // monotonized-central slope, half-LSB units
    function automatic longint mc_slope(input longint left, input longint right);
        longint m;
        longint t;
        if (!((left > 0 && right > 0) || (left < 0 && right < 0)))
            return 0;
        m = 4 * abs_val(left);
        t = abs_val(left + right);
        if (t < m)
            m = t;
        t = 4 * abs_val(right);
        if (t < m)
            m = t;
        return (right > 0) ? m : -m;
    endfunction

    function automatic void advect_step(input logic [SAMPLE_BITS-1:0] raw, input logic row_start);
        longint s;
        longint left;
        longint right;
        longint prev;
        longint d;
        longint c;
        longint num;
        longint res;
        s = $signed(raw);
        if (row_start)
        begin
            centre_win[0] = 0;
            centre_win[1] = 0;
            centre_win[2] = 0;
            win_fill = 0;
        end
        if (win_fill < 3)
        begin
            centre_win[win_fill] = s;
            win_fill++;
            return;
        end
        left  = centre_win[2] - centre_win[1];
        right = s - centre_win[2];
        prev  = centre_win[1] - centre_win[0];
        d     = cfg_mode ? (mc_slope(left, right) - mc_slope(prev, left)) : 0;
        c     = cfg_courant;
        num   = (centre_win[2] <<< ROUND_SHIFT) - ((left * c) <<< LEFT_SHIFT)
              - d * c * (longint'(ONE_Q16) - c) + (longint'(1) <<< (ROUND_SHIFT - 1));
        res   = clamp_sample(num >>> ROUND_SHIFT);
        expected_values.push_back(SAMPLE_BITS'(res));
        centre_win[0] = centre_win[1];
        centre_win[1] = centre_win[2];
        centre_win[2] = s;
    endfunction

    // scoreboard and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                updates_checked++;
                if (expected_values.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected new_value: expected none actual %0d",
                             $time, $signed(m_tdata[SAMPLE_BITS-1:0]));
                end
                else
                begin
                    expected_value = expected_values.pop_front();
                    if (m_tdata[SAMPLE_BITS-1:0] !== expected_value)
                    begin
                        errors++;
                        $display("%0t new_value mismatch: expected %0d actual %0d", $time,
                                 $signed(expected_value), $signed(m_tdata[SAMPLE_BITS-1:0]));
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                samples_taken++;
                advect_step(s_tdata[SAMPLE_BITS-1:0], s_tuser);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                    watchdog_fired = 1'b1;
            end
        end
    end

    initial
    begin
        wait (watchdog_fired);
        $display("%0t watchdog: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // output side: random stalls plus one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_done != hold_token)
        begin
            hold_done <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input logic first);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= DATA_W'(value);
        s_tuser  <= first;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_row(input longint vals[$]);
        foreach (vals[i])
            send_sample(SAMPLE_BITS'(vals[i]), i == 0);
    endtask

    // called at the step of the last handshake
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MODE)
            cfg_mode = data[0];
        else if (addr == ADDR_COURANT)
            cfg_courant = data[COURANT_W-1:0];
    endtask

    task automatic apb_check(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata !== value)
        begin
            errors++;
            $display("%0t register 0x%0h readback: expected 0x%0h actual 0x%0h",
                     $time, addr, value, prdata);
        end
    endtask

    task automatic set_config(input logic mode, input logic [COURANT_W-1:0] courant);
        wait_drained();
        apb_write(ADDR_MODE, CFG_DATA_W'(mode));
        apb_check(ADDR_MODE, CFG_DATA_W'(mode));
        apb_write(ADDR_COURANT, CFG_DATA_W'(courant));
        apb_check(ADDR_COURANT, CFG_DATA_W'(courant));
        @(posedge clk);
    endtask

    function automatic longint next_sample(input profile_t prof, input longint prev,
                                           input longint step);
        longint pick;
        case (prof)
            PROF_NOISE:
                return $signed(SAMPLE_BITS'($urandom()));
            PROF_WALK:
                return clamp_sample(prev + longint'($urandom_range(2 * step)) - step);
            PROF_EXTREME:
            begin
                pick = $urandom_range(4);
                case (pick)
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            default:
                return clamp_sample(prev + (($urandom_range(7) == 0) ? -step : step));
        endcase
    endfunction

    task automatic test_reset_values();
        apb_check(ADDR_MODE, CFG_DATA_W'(MODE_RESET));
        apb_check(ADDR_COURANT, CFG_DATA_W'(COURANT_RESET));
        @(posedge clk);
    endtask

    task automatic test_directed();
        // smooth data, sign change and flat spot under the limiter
        send_row('{0, 100, 300, 200, -50, -50, 40});
        send_row('{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX});
        // row restarted before the window fills
        send_sample(SAMPLE_BITS'(5), 1'b1);
        send_sample(SAMPLE_BITS'(7), 1'b0);
        send_row('{-3, 9, -3, 9});
        set_config(1'b0, 16'hffff);
        send_row('{SAMPLE_MIN, SAMPLE_MAX, 0, SAMPLE_MIN, -1});
        // zero Courant number leaves the centre value
        set_config(1'b1, 16'h0000);
        send_row('{10, -20, 30, -40});
    endtask

    task automatic test_random_section(input logic mode, input logic [COURANT_W-1:0] courant,
                                       input int tx_pct, input int rx_pct);
        int       sent;
        int       len;
        logic     first;
        longint   value;
        longint   step;
        profile_t prof;
        set_config(mode, courant);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        sent  = 0;
        value = 0;
        while (sent < SECTION_ITEMS)
        begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(3, 24);
            prof = profile_t'($urandom_range(9) < 5 ? PROF_WALK : $urandom_range(3));
            step = longint'(1) <<< $urandom_range(20);
            value = $signed(SAMPLE_BITS'($urandom()));
            for (int k = 0; k < len; k++)
            begin
                // mostly clean rows; some rows run on, some restart early
                first = (k == 0) ? ($urandom_range(19) != 0) : ($urandom_range(49) == 0);
                value = next_sample(prof, value, step);
                send_sample(SAMPLE_BITS'(value), first);
                sent++;
            end
        end
    endtask

    task automatic test_output_stall();
        longint value;
        set_config(1'b1, COURANT_W'($urandom_range(1, 65535)));
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_token++;
        value = 0;
        for (int k = 0; k < 30; k++)
        begin
            value = next_sample(PROF_WALK, value, 4096);
            send_sample(SAMPLE_BITS'(value), k == 0);
        end
    endtask

    task automatic test_sender_pause();
        longint value;
        value = 0;
        for (int k = 0; k < 20; k++)
        begin
            if (k == 10)
                wait_drained();
            value = next_sample(PROF_WALK, value, 65536);
            send_sample(SAMPLE_BITS'(value), k == 0);
        end
    endtask

    initial
    begin
        centre_win[0] = 0;
        centre_win[1] = 0;
        centre_win[2] = 0;
        win_fill      = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed();
        test_random_section(1'b1, COURANT_W'($urandom_range(1, 65535)), 15, 65);
        test_random_section(1'b0, COURANT_W'($urandom_range(1, 65535)), 15, 65);
        test_random_section(1'b1, 16'hffff, 65, 15);
        test_random_section(1'b0, 16'h0001, 65, 15);
        test_random_section(1'b1, 16'h0001, 0, 0);
        test_output_stall();
        test_sender_pause();
        test_random_section(1'b1, COURANT_W'($urandom_range(1, 65535)), 0, 0);

        wait_drained();
        if (expected_values.size() != 0)
        begin
            errors++;
            $display("%0t %0d updated values never arrived", $time, expected_values.size());
        end
        $display("summary: %0d samples accepted, %0d updated values checked, %0d errors",
                 samples_taken, updates_checked, errors);
        $display("summary: upwind and limited modes, Courant 0 to 0xffff, stalls on both sides");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
